// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by lfu_slot_replacement.sv
// each macro expects clk and arst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/lfu_pkg.sv -----
// constants and types of the lfu slot replacement block
// no dependencies
package lfu_pkg;
	localparam int MAX_SLOTS   = 32;
	localparam int ID_WIDTH    = 10;
	localparam int COUNT_WIDTH = 16;
	localparam int CFG_W       = 6;
	localparam int SLOT_AW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int OCC_W       = $clog2(MAX_SLOTS + 1);
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// operation codes of an input word
	localparam logic OP_VOTE    = 1'b0;
	localparam logic OP_READOUT = 1'b1;

	typedef struct packed {
		logic [ID_WIDTH-1:0]    ident;
		logic [COUNT_WIDTH-1:0] hits;
	} slot_t;

	typedef struct packed {
		logic               we;
		logic [SLOT_AW-1:0] addr;
		slot_t              data;
	} lfu_wr_t;

	typedef struct packed {
		logic                was_hit;
		logic                evicted_valid;
		logic [ID_WIDTH-1:0] evicted_id;
		logic                listed_valid;
		logic [ID_WIDTH-1:0] listed_id;
		logic                last;
	} lfu_result_t;

	typedef struct packed {
		logic             busy;
		logic [OCC_W-1:0] occ;
	} lfu_status_t;
endpackage

// ----- hw/rtl/lfu_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/lfu_ctrl.sv -----
// sequencer of the lfu block: scans, updates and shifts the slot ram, builds result words
// depends on lfu_pkg
module lfu_ctrl import lfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               operation,
	input  logic [ID_WIDTH-1:0] candidate_id,
	input  logic [CFG_W-1:0]   active_slots,
	input  logic               res_ready,
	output logic               res_valid,
	output lfu_result_t        res,
	output lfu_status_t        status,
	output lfu_wr_t            mem_wr,
	output logic [SLOT_AW-1:0] mem_raddr,
	input  slot_t              mem_rdata
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;
	localparam logic [2:0] ST_LSCAN  = 3'd5;

	logic [2:0]             state_q;
	logic [OCC_W-1:0]       occ_q;
	logic                   rd_s1;
	logic [SLOT_AW-1:0]     idx_s1;
	logic [OCC_W-1:0]       raddr_q;
	logic [ID_WIDTH-1:0]    id_q;
	logic                   hit_q;
	logic [SLOT_AW-1:0]     hit_idx_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic [COUNT_WIDTH-1:0] min_cnt_q;
	logic [SLOT_AW-1:0]     min_idx_q;
	logic [ID_WIDTH-1:0]    min_id_q;
	logic                   found_q;
	logic [ID_WIDTH-1:0]    best_q;
	logic [ID_WIDTH-1:0]    prev_q;
	logic                   first_q;
	logic [OCC_W-1:0]       emit_cnt_q;
	logic                   more_q;
	lfu_result_t            res_q;

	logic [OCC_W-1:0]       limit;
	logic                   accept;
	logic                   scanning;
	logic                   issue;
	logic                   scan_done;
	logic                   room;
	logic                   list_last;
	logic                   above_prev;
	logic                   better;
	logic [OCC_W-1:0]       occ_m1;
	logic [COUNT_WIDTH-1:0] hit_next;

	// register value zero acts as one, oversize acts as full depth
	always_comb begin
		if (active_slots == '0) begin
			limit = OCC_W'(1);
		end else if (active_slots > CFG_W'(MAX_SLOTS)) begin
			limit = OCC_W'(MAX_SLOTS);
		end else begin
			limit = OCC_W'(active_slots);
		end
	end

	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign scanning  = (state_q == ST_SCAN) || (state_q == ST_SHIFT) || (state_q == ST_LSCAN);
	assign issue     = scanning && (raddr_q < occ_q);
	assign scan_done = (raddr_q == occ_q) && !rd_s1;
	assign room      = occ_q < limit;
	assign occ_m1    = occ_q - OCC_W'(1);
	assign list_last = (emit_cnt_q + OCC_W'(1)) == occ_q;
	assign hit_next  = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + COUNT_WIDTH'(1);
	assign above_prev = first_q || (mem_rdata.ident > prev_q);
	assign better     = !found_q || (mem_rdata.ident < best_q);

	assign mem_raddr   = raddr_q[SLOT_AW-1:0];
	assign res_valid   = (state_q == ST_EMIT);
	assign res         = res_q;
	assign status.busy = (state_q != ST_IDLE);
	assign status.occ  = occ_q;

	always_comb begin
		mem_wr = '0;
		unique case (state_q)
			ST_DECIDE: begin
				if (hit_q) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = hit_idx_q;
					mem_wr.data = '{ident: id_q, hits: hit_next};
				end else if (room) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = occ_q[SLOT_AW-1:0];
					mem_wr.data = '{ident: id_q, hits: COUNT_WIDTH'(1)};
				end
			end
			ST_SHIFT: begin
				// younger entries move down one place, then the new word goes last
				if (rd_s1) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = idx_s1 - SLOT_AW'(1);
					mem_wr.data = mem_rdata;
				end else if (scan_done) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = occ_m1[SLOT_AW-1:0];
					mem_wr.data = '{ident: id_q, hits: COUNT_WIDTH'(1)};
				end
			end
			default: begin
				mem_wr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_VOTE) begin
							state_q <= ST_SCAN;
						end else if (occ_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_LSCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (hit_q) begin
						state_q <= ST_EMIT;
					end else if (room) begin
						occ_q   <= occ_q + OCC_W'(1);
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (scan_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_LSCAN: begin
					if (scan_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= more_q ? ST_LSCAN : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= raddr_q[SLOT_AW-1:0];
		if (issue) begin
			raddr_q <= raddr_q + OCC_W'(1);
		end
		unique case (state_q)
			ST_IDLE: begin
				id_q       <= candidate_id;
				raddr_q    <= '0;
				hit_q      <= 1'b0;
				found_q    <= 1'b0;
				first_q    <= 1'b1;
				emit_cnt_q <= '0;
				more_q     <= 1'b0;
				res_q      <= '{default: '0, last: 1'b1};
			end
			ST_SCAN: begin
				if (rd_s1) begin
					if (mem_rdata.ident == id_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
						hit_cnt_q <= mem_rdata.hits;
					end
					// strict less keeps the oldest among equal counts
					if (idx_s1 == '0 || mem_rdata.hits < min_cnt_q) begin
						min_cnt_q <= mem_rdata.hits;
						min_idx_q <= idx_s1;
						min_id_q  <= mem_rdata.ident;
					end
				end
			end
			ST_DECIDE: begin
				if (hit_q) begin
					res_q <= '{default: '0, was_hit: 1'b1, last: 1'b1};
				end else if (!room) begin
					res_q   <= '{default: '0, evicted_valid: 1'b1, evicted_id: min_id_q,
						last: 1'b1};
					raddr_q <= OCC_W'(min_idx_q) + OCC_W'(1);
				end else begin
					res_q <= '{default: '0, last: 1'b1};
				end
			end
			ST_LSCAN: begin
				// each pass picks the smallest identifier above the one listed before
				if (rd_s1 && above_prev && better) begin
					found_q <= 1'b1;
					best_q  <= mem_rdata.ident;
				end
				if (scan_done) begin
					res_q      <= '{default: '0, listed_valid: 1'b1, listed_id: best_q,
						last: list_last};
					more_q     <= !list_last;
					prev_q     <= best_q;
					first_q    <= 1'b0;
					emit_cnt_q <= emit_cnt_q + OCC_W'(1);
				end
			end
			ST_EMIT: begin
				raddr_q <= '0;
				found_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end
endmodule

// ----- hw/rtl/lfu_slot_replacement.sv -----
// lfu slot replacement: a vote scans the held slots, plus a shifting scan when it evicts;
// the scans read one ram slot per cycle while the block is busy with the item.
// a read-out gives its result words one after another, one ram scan per word.
// one item at a time; a result word waits in the output register while the next item runs.
// arst_n clears occupancy, control state and the output valid flag; active_slots reads 32.
// ram contents are not cleared, only occupied slots are read.
module lfu_slot_replacement import lfu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [ID_WIDTH-1:0] candidate_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                was_hit,
	output logic                evicted_valid,
	output logic [ID_WIDTH-1:0] evicted_id,
	output logic                listed_valid,
	output logic [ID_WIDTH-1:0] listed_id,
	output logic                last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    active_slots
);
	`include "assert_macros.svh"

	logic [CFG_W-1:0]   active_slots_q;
	logic               out_valid_q;
	lfu_result_t        out_q;
	logic               res_valid;
	logic               res_ready;
	lfu_result_t        res;
	lfu_status_t        status;
	lfu_wr_t            mem_wr;
	logic [SLOT_AW-1:0] mem_raddr;
	slot_t              mem_rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = status.busy;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= CFG_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_slots_q <= active_slots;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	lfu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.operation    (operation),
		.candidate_id (candidate_id),
		.active_slots (active_slots_q),
		.res_ready    (res_ready),
		.res_valid    (res_valid),
		.res          (res),
		.status       (status),
		.mem_wr       (mem_wr),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	lfu_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (MAX_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_wr.we),
		.waddr (mem_wr.addr),
		.wdata (mem_wr.data),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_valid     = out_valid_q;
	assign was_hit       = out_q.was_hit;
	assign evicted_valid = out_q.evicted_valid;
	assign evicted_id    = out_q.evicted_id;
	assign listed_valid  = out_q.listed_valid;
	assign listed_id     = out_q.listed_id;
	assign last          = out_q.last;

	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`ASSERT_ALWAYS(a_occ_bound, status.occ <= OCC_W'(MAX_SLOTS))
	`ASSERT_IMPL(a_only_listing_continues, out_valid && !last, listed_valid && !was_hit)
	`ASSERT_IMPL(a_hit_no_evict, out_valid && was_hit, !evicted_valid && last)
endmodule
